### rtl/core/esid_pkg.sv
// Shared types, constants and arithmetic steps of the symmetry index decoder.
`default_nettype none
package esid_pkg;

  localparam int unsigned MAX_DIM      = 1024;
  localparam int unsigned DIM_W        = 11;
  localparam int unsigned STEPS        = 3;   // root digits resolved per stage
  localparam int unsigned BIG_STAGES   = 7;   // 21 digits of a 42-bit radicand
  localparam int unsigned SMALL_STAGES = 4;   // 12 digits of a 24-bit radicand
  localparam int unsigned NUM_STAGES   = BIG_STAGES + SMALL_STAGES + 3;

  localparam logic REG_MATRIX_DIM    = 1'b0;
  localparam logic REG_SYMMETRY_MODE = 1'b1;

  // Operand codes 0 = i, 1 = j, 2 = k, 3 = l; entry = {row, col}.
  localparam logic [3:0] SEL_TABLE [32] = '{
    4'd1,  4'd4,  4'd1,  4'd4,  4'd11, 4'd14, 4'd11, 4'd14,
    4'd11, 4'd11, 4'd14, 4'd14, 4'd1,  4'd1,  4'd4,  4'd4,
    4'd9,  4'd8,  4'd13, 4'd12, 4'd3,  4'd2,  4'd7,  4'd6,
    4'd3,  4'd7,  4'd2,  4'd6,  4'd9,  4'd13, 4'd8,  4'd12
  };

  typedef struct packed {
    logic [23:0] rem;
    logic [20:0] root;
  } sq_t;

  typedef struct packed {
    logic [19:0] root_idx;
    logic [19:0] rest;
  } split_t;

  // One digit of the restoring square root.
  function automatic sq_t sq_step(input sq_t cur, input logic [1:0] pair);
    sq_t         nxt;
    logic [23:0] acc;
    logic [23:0] trial;
    acc   = {cur.rem[21:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (acc >= trial) begin
      nxt.rem  = acc - trial;
      nxt.root = {cur.root[19:0], 1'b1};
    end else begin
      nxt.rem  = acc;
      nxt.root = {cur.root[19:0], 1'b0};
    end
    return nxt;
  endfunction

  // From s = isqrt(8x+1) and its remainder, form the triangular root of x
  // and what is left of x above the triangular number.
  function automatic split_t tri_split(input sq_t sq);
    split_t      res;
    logic [20:0] sm1;
    logic [24:0] sum;
    sm1 = sq.root - 21'd1;
    sum = {1'b0, sq.rem} + {3'b000, sq.root, 1'b0} - 25'd1;
    res.root_idx = sm1[20:1];
    res.rest     = sq.root[0] ? sq.rem[22:3] : sum[22:3];
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/eri_symmetry_index_decode.sv
// Pipelined pair-of-pairs index decoder with eightfold symmetry selection.
//
// The input channel carries one packed index per beat, packed_low plus
// packed_high times two to the 31. The block takes its triangular root to
// get the pair indices ij and kl, splits each again into i,j and k,l, and
// returns row * matrix_dim + col for the row and column that symmetry_mode
// picks, together with a flag when any of i, j, k, l is not below the
// dimension (the flat index then reads zero). matrix_dim saturates at 1024.
// A new beat is taken every cycle unless the output stalls. The pipe has
// seven stages of a 21-digit square root, a split stage, four stages of
// two 12-digit roots in parallel, a decode stage and the multiply-add
// output register, three root digits per stage. All stages move together;
// when the output holds a beat and the receiver stalls, the whole pipe
// freezes and in_stall_o rises, so nothing is lost or repeated. Reset
// empties the pipe and loads matrix_dim = 1 and symmetry_mode = 0. The user
// must write configuration only while the pipe is empty; the block does not enforce it.
`default_nettype none
module eri_symmetry_index_decode (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [30:0] packed_low_i,
  input  wire logic [6:0]  packed_high_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [19:0]      flat_index_o,
  output logic             out_of_range_o
);

  typedef struct packed {
    logic [41:0]      n;
    esid_pkg::sq_t    sq;
  } big_t;

  typedef struct packed {
    logic [23:0]      n;
    esid_pkg::sq_t    sq;
  } small_t;

  logic [10:0] matrix_dim_q;
  logic [4:0]  symmetry_mode_q;
  logic [esid_pkg::NUM_STAGES-1:0] vld_q;
  logic        en;

  big_t   big_q [esid_pkg::BIG_STAGES];
  esid_pkg::split_t mid_q;
  small_t sm_q  [esid_pkg::SMALL_STAGES][2];
  logic [10:0] idx_q [4];
  logic        bad_q;
  logic [19:0] flat_q;
  logic        oor_q;

  // The whole pipe advances unless a finished beat waits at the output.
  assign en         = !(vld_q[esid_pkg::NUM_STAGES-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_dim_q    <= 11'd1;
      symmetry_mode_q <= 5'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esid_pkg::REG_MATRIX_DIM:    matrix_dim_q    <= cfg_wdata_i;
        esid_pkg::REG_SYMMETRY_MODE: symmetry_mode_q <= cfg_wdata_i[4:0];
        default:                     matrix_dim_q    <= matrix_dim_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[esid_pkg::NUM_STAGES-2:0], in_valid_i};
    end
  end

  // Main root: radicand 8v+1 with v up to 38 bits.
  for (genvar g = 0; g < esid_pkg::BIG_STAGES; g++) begin : g_big
    big_t src;
    big_t nxt;
    if (g == 0) begin : g_first
      assign src = '{n: {1'b0, packed_high_i, packed_low_i, 3'b001}, sq: '0};
    end else begin : g_rest
      assign src = big_q[g-1];
    end
    always_comb begin
      nxt = src;
      for (int t = 0; t < esid_pkg::STEPS; t++) begin
        nxt.sq = esid_pkg::sq_step(nxt.sq, nxt.n[41:40]);
        nxt.n  = {nxt.n[39:0], 2'b00};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        big_q[g] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_q <= esid_pkg::tri_split(big_q[esid_pkg::BIG_STAGES-1].sq);
    end
  end

  // mid_q.root_idx is ij, mid_q.rest is kl; both lanes get their own root.
  for (genvar g = 0; g < esid_pkg::SMALL_STAGES; g++) begin : g_small
    for (genvar h = 0; h < 2; h++) begin : g_lane
      small_t src;
      small_t nxt;
      if (g == 0) begin : g_first
        assign src = '{n: {1'b0, (h == 0) ? mid_q.root_idx : mid_q.rest, 3'b001},
                       sq: '0};
      end else begin : g_rest
        assign src = sm_q[g-1][h];
      end
      always_comb begin
        nxt = src;
        for (int t = 0; t < esid_pkg::STEPS; t++) begin
          nxt.sq = esid_pkg::sq_step(nxt.sq, nxt.n[23:22]);
          nxt.n  = {nxt.n[21:0], 2'b00};
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          sm_q[g][h] <= nxt;
        end
      end
    end
  end

  // Decode stage: i, j, k, l and the range check against the saturated dim.
  logic [10:0]      dim_eff;
  esid_pkg::split_t sp_ij;
  esid_pkg::split_t sp_kl;
  logic [10:0]      idx_d [4];
  logic             bad_d;

  assign dim_eff = (matrix_dim_q > 11'(esid_pkg::MAX_DIM)) ? 11'(esid_pkg::MAX_DIM)
                                                           : matrix_dim_q;

  always_comb begin
    sp_ij    = esid_pkg::tri_split(sm_q[esid_pkg::SMALL_STAGES-1][0].sq);
    sp_kl    = esid_pkg::tri_split(sm_q[esid_pkg::SMALL_STAGES-1][1].sq);
    idx_d[0] = sp_ij.root_idx[10:0];
    idx_d[1] = sp_ij.rest[10:0];
    idx_d[2] = sp_kl.root_idx[10:0];
    idx_d[3] = sp_kl.rest[10:0];
    bad_d    = (idx_d[0] >= dim_eff) || (idx_d[1] >= dim_eff) ||
               (idx_d[2] >= dim_eff) || (idx_d[3] >= dim_eff);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q <= idx_d;
      bad_q <= bad_d;
    end
  end

  // Output stage: pick row and column, multiply-add into the flat index.
  logic [3:0]  sel;
  logic [22:0] flat_full;

  always_comb begin
    sel       = esid_pkg::SEL_TABLE[symmetry_mode_q];
    flat_full = 23'(idx_q[sel[3:2]] * dim_eff) + {12'd0, idx_q[sel[1:0]]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flat_q <= bad_q ? 20'd0 : flat_full[19:0];
      oor_q  <= bad_q;
    end
  end

  assign out_valid_o    = vld_q[esid_pkg::NUM_STAGES-1];
  assign flat_index_o   = flat_q;
  assign out_of_range_o = oor_q;

endmodule
`default_nettype wire
